/* rtl/core/cmag_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmag_pkg
// Shared widths and data types for the cordic magnitude pipeline.
// ----------------------------------------------------------------------------
package cmag_pkg;

	// word width and number of micro-rotation cells
	localparam int DATA_BITS  = 16;
	localparam int ROUNDS     = 8;
	localparam int SHIFT_BITS = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	typedef logic signed [DATA_BITS-1:0] word_t;
	typedef logic [SHIFT_BITS-1:0]       shift_t;

	// working vector and companion vector carried down the chain
	typedef struct packed {
		word_t x;
		word_t y;
		word_t x2;
		word_t y2;
	} vec_t;

endpackage
`default_nettype wire

/* rtl/core/cmag_fold.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmag_fold
// Entry stage: folds the vector into the right half plane, negating x and
// the companion x when x is negative, and registers the result.
// ----------------------------------------------------------------------------
module cmag_fold (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cmag_pkg::vec_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output cmag_pkg::vec_t     out_data
);
	import cmag_pkg::*;

	logic valid_q;
	vec_t data_q;
	vec_t folded;

	// stage takes a transaction when empty or when it drains this cycle
	assign in_ready = !valid_q || out_ready;

	// negate x and companion x for the left half plane, wrapping at word width
	always_comb begin
		folded = in_data;
		if (in_data.x[DATA_BITS-1]) begin
			folded.x  = -in_data.x;
			folded.x2 = -in_data.x2;
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= folded;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
`default_nettype wire

/* rtl/core/cmag_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmag_cell
// One micro-rotation cell: rotates both vectors by the sign of y using
// arithmetic shifts by the cell's position, then registers them.
// ----------------------------------------------------------------------------
module cmag_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cmag_pkg::shift_t shift,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire cmag_pkg::vec_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output cmag_pkg::vec_t       out_data
);
	import cmag_pkg::*;

	logic  valid_q;
	vec_t  data_q;
	vec_t  rotated;
	word_t sh_x, sh_y, sh_x2, sh_y2;
	logic  y_neg;

	assign in_ready = !valid_q || out_ready;

	// shifted cross terms
	assign sh_x  = in_data.x  >>> shift;
	assign sh_y  = in_data.y  >>> shift;
	assign sh_x2 = in_data.x2 >>> shift;
	assign sh_y2 = in_data.y2 >>> shift;
	assign y_neg = in_data.y[DATA_BITS-1];

	// rotation direction set by main y, applied to both vectors
	always_comb begin
		if (y_neg) begin
			rotated.x  = in_data.x  - sh_y;
			rotated.y  = in_data.y  + sh_x;
			rotated.x2 = in_data.x2 - sh_y2;
			rotated.y2 = in_data.y2 + sh_x2;
		end else begin
			rotated.x  = in_data.x  + sh_y;
			rotated.y  = in_data.y  - sh_x;
			rotated.x2 = in_data.x2 + sh_y2;
			rotated.y2 = in_data.y2 - sh_x2;
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= rotated;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
`default_nettype wire

/* rtl/core/cordic_magnitude_with_companion_rotate.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_magnitude_with_companion_rotate
// Vectoring-mode cordic magnitude with a companion vector rotated alongside.
//
// Usage:
//   Input channel (in_valid/in_ready) carries vec_x, vec_y, comp_x_in and
//   comp_y; output channel (out_valid/out_ready) carries magnitude and
//   comp_x_out, one result transaction per input transaction, in order.
//   Between input acceptance and output valid lie one fold stage, one cell
//   per micro-rotation (8), and the gain-correction output register.
//   Throughput is one transaction per cycle while the receiver keeps up; the
//   chain of cells is fully pipelined with one register per cell.
//   Each stage has its own valid bit and takes a new transaction when empty
//   or when draining, so bubbles close up. When the receiver stalls, results
//   pile up stage by stage and in_ready falls only once every stage is full.
//   Reset empties all stages; no result is pending after reset.
//   Every working value wraps at 16 bits; nothing saturates.
// ----------------------------------------------------------------------------
module cordic_magnitude_with_companion_rotate (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire cmag_pkg::word_t vec_x,
	input  wire cmag_pkg::word_t vec_y,
	input  wire cmag_pkg::word_t comp_x_in,
	input  wire cmag_pkg::word_t comp_y,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output cmag_pkg::word_t      magnitude,
	output cmag_pkg::word_t      comp_x_out
);
	import cmag_pkg::*;

	vec_t        in_vec;
	vec_t        stage_data  [ROUNDS+1];
	logic [ROUNDS:0] stage_valid;
	logic [ROUNDS:0] stage_ready;
	logic        last_ready;
	logic        out_valid_q;
	word_t       mag_q;
	word_t       cx_q;
	word_t       mag_fix;
	word_t       cx_fix;

	assign in_vec = '{x: vec_x, y: vec_y, x2: comp_x_in, y2: comp_y};

	// fold into the right half plane
	cmag_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_vec),
		.out_valid (stage_valid[0]),
		.out_ready (stage_ready[0]),
		.out_data  (stage_data[0])
	);

	// chain of micro-rotation cells, cell i shifts by i
	for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
		cmag_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (SHIFT_BITS'(i)),
			.in_valid  (stage_valid[i]),
			.in_ready  (stage_ready[i]),
			.in_data   (stage_data[i]),
			.out_valid (stage_valid[i+1]),
			.out_ready (stage_ready[i+1]),
			.out_data  (stage_data[i+1])
		);
	end

	assign stage_ready[ROUNDS] = last_ready;
	assign last_ready          = !out_valid_q || out_ready;

	// gain correction: about 0.625 as (v >> 1) + (v >> 3)
	assign mag_fix = (stage_data[ROUNDS].x  >>> 1) + (stage_data[ROUNDS].x  >>> 3);
	assign cx_fix  = (stage_data[ROUNDS].x2 >>> 1) + (stage_data[ROUNDS].x2 >>> 3);

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_ready) begin
			out_valid_q <= stage_valid[ROUNDS];
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (stage_valid[ROUNDS] && last_ready) begin
			mag_q <= mag_fix;
			cx_q  <= cx_fix;
		end
	end

	assign out_valid  = out_valid_q;
	assign magnitude  = mag_q;
	assign comp_x_out = cx_q;

`ifndef SYNTHESIS
	logic [ROUNDS+1:0] occ;
	logic              take_in;
	logic              give_out;

	assign occ      = {out_valid_q, stage_valid};
	assign take_in  = in_valid && in_ready;
	assign give_out = out_valid && out_ready;

	// a transaction taken and none delivered grows occupancy by one
	a_occ_grow: assert property (@(posedge clk) disable iff (!arst_n)
		take_in && !give_out |=> $countones(occ) == $past($countones(occ)) + 1)
		else $error("occupancy did not grow on input transaction");

	// a transaction delivered and none taken shrinks occupancy by one
	a_occ_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		!take_in && give_out |=> $countones(occ) + 1 == $past($countones(occ)))
		else $error("occupancy did not shrink on output transaction");

	// input back-pressure only when every stage is full and the output stalls
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&occ) && !out_ready)
		else $error("input stalled with room in the pipeline");

	// corrected magnitude stays within the range of the gain correction
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(magnitude) >= -20480) && ($signed(magnitude) <= 20478))
		else $error("magnitude out of range");
`endif

endmodule
`default_nettype wire
